// ===== src/miller_rabin_single_base_macros.svh =====
// Assertion macros for the miller_rabin_single_base block.
// Used by the modules that carry concurrent checks; they expect clk and rst_n.
`ifndef MILLER_RABIN_SINGLE_BASE_MACROS_SVH
`define MILLER_RABIN_SINGLE_BASE_MACROS_SVH

// property holds on every edge outside reset
`define MRSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define MRSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mrsb_pkg.sv =====
// Package for the miller_rabin_single_base block: word types, datapath
// commands and status flags shared by controller and datapath. No dependencies.
package mrsb_pkg;

  localparam int FIELD_W   = 64;
  localparam int WIDTH_DEF = 64;

  typedef struct packed {
    logic [FIELD_W-1:0] candidate;
    logic [FIELD_W-1:0] witness_base;
  } mrsb_in_t;

  typedef struct packed {
    logic probable_prime;
    logic invalid;
  } mrsb_out_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_GCD_STEP,
    OP_SPLIT_INIT,
    OP_SPLIT_STEP,
    OP_POW_INIT,
    OP_E_SHIFT,
    OP_T_DEC
  } mrsb_op_t;

  typedef enum logic [1:0] {
    MUL_RB,
    MUL_BB,
    MUL_RR
  } mrsb_mul_sel_t;

  typedef struct packed {
    mrsb_op_t      op;
    logic          mul_start;
    mrsb_mul_sel_t mul_sel;
  } mrsb_cmd_t;

  typedef struct packed {
    logic n_lt3;
    logic a_bad;
    logic n_even;
    logic gv_zero;
    logic gu_one;
    logic e_zero;
    logic e_lsb;
    logic x_one;
    logic x_nm1;
    logic t_one;
    logic mul_done;
  } mrsb_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GCD,
    S_SPLIT,
    S_POW_TEST,
    S_POW_WRB,
    S_POW_WBB,
    S_EVAL,
    S_SQ_TEST,
    S_SQ_WAIT,
    S_SQ_CHK,
    S_DONE
  } mrsb_state_t;

endpackage

// ===== src/mrsb_mulmod.sv =====
// Bit-serial modular multiplier (double-and-add, MSB first), a doubling phase then an add phase for each bit.
// Depends on mrsb_pkg and the block's assertion macros.
`include "miller_rabin_single_base_macros.svh"
module mrsb_mulmod import mrsb_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] op_x,
  input  logic [WIDTH-1:0] op_y,
  input  logic [WIDTH-1:0] modulus,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int CW = $clog2(WIDTH);

  logic             busy_r, done_r, phase_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] acc_r, x_r, y_r, m_r;
  logic [WIDTH:0]   sum, red;
  logic             last;

  // phase 0 doubles the accumulator, phase 1 conditionally adds x
  always_comb begin
    sum  = {1'b0, acc_r} + {1'b0, (phase_r ? x_r : acc_r)};
    red  = (sum >= {1'b0, m_r}) ? (sum - {1'b0, m_r}) : sum;
    last = phase_r && (cnt_r == CW'(WIDTH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        cnt_r   <= '0;
      end else if (busy_r) begin
        phase_r <= ~phase_r;
        if (phase_r) cnt_r <= cnt_r + CW'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= op_x;
      y_r   <= op_y;
      m_r   <= modulus;
    end else if (busy_r) begin
      if (!phase_r) begin
        acc_r <= red[WIDTH-1:0];
      end else begin
        if (y_r[WIDTH-1]) acc_r <= red[WIDTH-1:0];
        y_r <= {y_r[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = acc_r;

  `MRSB_ASSERT(a_no_start_busy, !(start && busy_r), "mulmod started while busy")
  `MRSB_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "mulmod done longer than one cycle")
  `MRSB_ASSERT_NEXT(a_done_after_last, busy_r && last && !start, done_r && !busy_r,
                    "mulmod did not finish after last bit")

endmodule

// ===== src/mrsb_datapath.sv =====
// Datapath: operand registers, binary gcd, n-1 split, exponent and square
// registers around the shared modular multiplier. Depends on mrsb_pkg, mrsb_mulmod.
module mrsb_datapath import mrsb_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mrsb_in_t  in_word,
  input  mrsb_cmd_t cmd,
  output mrsb_sts_t sts
);

  localparam int TW = $clog2(WIDTH);

  logic [WIDTH-1:0] n_r, a_r, gu_r, gv_r, e_r, r_r, b_r;
  logic [TW-1:0]    t_r;
  logic             dest_b_r;
  logic [WIDTH-1:0] nm1;
  logic [WIDTH-1:0] mx, my, mres;
  logic             mbusy, mdone;

  assign nm1 = n_r - WIDTH'(1);

  always_comb begin
    case (cmd.mul_sel)
      MUL_RB:  begin mx = r_r; my = b_r; end
      MUL_BB:  begin mx = b_r; my = b_r; end
      MUL_RR:  begin mx = r_r; my = r_r; end
      default: begin mx = r_r; my = r_r; end
    endcase
  end

  mrsb_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .op_x    (mx),
    .op_y    (my),
    .modulus (n_r),
    .busy    (mbusy),
    .done    (mdone),
    .result  (mres)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_start) dest_b_r <= (cmd.mul_sel == MUL_BB);
    if (mdone) begin
      if (dest_b_r) b_r <= mres;
      else          r_r <= mres;
    end
    case (cmd.op)
      OP_LOAD: begin
        n_r  <= in_word.candidate[WIDTH-1:0];
        a_r  <= in_word.witness_base[WIDTH-1:0];
        gu_r <= in_word.candidate[WIDTH-1:0];
        gv_r <= in_word.witness_base[WIDTH-1:0];
      end
      OP_GCD_STEP: begin
        // gu stays odd; gv is reduced until zero
        if (!gv_r[0])          gv_r <= gv_r >> 1;
        else if (gv_r >= gu_r) gv_r <= gv_r - gu_r;
        else begin
          gu_r <= gv_r;
          gv_r <= gu_r - gv_r;
        end
      end
      OP_SPLIT_INIT: begin
        e_r <= nm1;
        t_r <= '0;
      end
      OP_SPLIT_STEP: begin
        e_r <= e_r >> 1;
        t_r <= t_r + TW'(1);
      end
      OP_POW_INIT: begin
        r_r <= WIDTH'(1);
        b_r <= a_r;
      end
      OP_E_SHIFT: e_r <= e_r >> 1;
      OP_T_DEC:   t_r <= t_r - TW'(1);
      default: ;
    endcase
  end

  always_comb begin
    sts.n_lt3    = (n_r < WIDTH'(3));
    sts.a_bad    = (a_r == '0) || (a_r >= n_r);
    sts.n_even   = ~n_r[0];
    sts.gv_zero  = (gv_r == '0);
    sts.gu_one   = (gu_r == WIDTH'(1));
    sts.e_zero   = (e_r == '0);
    sts.e_lsb    = e_r[0];
    sts.x_one    = (r_r == WIDTH'(1));
    sts.x_nm1    = (r_r == nm1);
    sts.t_one    = (t_r == TW'(1));
    sts.mul_done = mdone && !mbusy;
  end

endmodule

// ===== src/mrsb_ctrl.sv =====
// Controller: sequences checks, gcd, split, exponentiation and squarings, and
// holds the output word register. Depends on mrsb_pkg and the assertion macros.
`include "miller_rabin_single_base_macros.svh"
module mrsb_ctrl import mrsb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output mrsb_out_t out_word,
  output mrsb_cmd_t cmd,
  input  mrsb_sts_t sts
);

  mrsb_state_t state_r, state_nxt;
  logic        out_valid_r;
  mrsb_out_t   out_word_r;
  logic        res_pp_r, res_inv_r;
  logic        set_res, res_pp, res_inv;
  logic        out_free, in_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (sts.n_lt3 || sts.a_bad || sts.n_even) state_nxt = S_DONE;
        else                                     state_nxt = S_GCD;
      end
      S_GCD: begin
        if (sts.gv_zero) state_nxt = sts.gu_one ? S_SPLIT : S_DONE;
      end
      S_SPLIT:    if (sts.e_lsb) state_nxt = S_POW_TEST;
      S_POW_TEST: begin
        if (sts.e_zero)     state_nxt = S_EVAL;
        else if (sts.e_lsb) state_nxt = S_POW_WRB;
        else                state_nxt = S_POW_WBB;
      end
      S_POW_WRB:  if (sts.mul_done) state_nxt = S_POW_WBB;
      S_POW_WBB:  if (sts.mul_done) state_nxt = S_POW_TEST;
      S_EVAL:     state_nxt = (sts.x_one || sts.x_nm1) ? S_DONE : S_SQ_TEST;
      S_SQ_TEST:  state_nxt = sts.t_one ? S_DONE : S_SQ_WAIT;
      S_SQ_WAIT:  if (sts.mul_done) state_nxt = S_SQ_CHK;
      S_SQ_CHK:   state_nxt = sts.x_nm1 ? S_DONE : S_SQ_TEST;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NOP;
    cmd.mul_start = 1'b0;
    cmd.mul_sel   = MUL_RR;
    set_res       = 1'b0;
    res_pp        = 1'b0;
    res_inv       = 1'b0;
    case (state_r)
      S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
      S_CHECK: begin
        set_res = 1'b1;
        res_inv = sts.n_lt3 || sts.a_bad;
      end
      S_GCD: begin
        if (!sts.gv_zero)     cmd.op = OP_GCD_STEP;
        else if (sts.gu_one)  cmd.op = OP_SPLIT_INIT;
        else                  set_res = 1'b1;
      end
      S_SPLIT: cmd.op = sts.e_lsb ? OP_POW_INIT : OP_SPLIT_STEP;
      S_POW_TEST: begin
        if (!sts.e_zero) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = sts.e_lsb ? MUL_RB : MUL_BB;
        end
      end
      S_POW_WRB: begin
        if (sts.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_BB;
        end
      end
      S_POW_WBB: if (sts.mul_done) cmd.op = OP_E_SHIFT;
      S_EVAL: begin
        set_res = 1'b1;
        res_pp  = 1'b1;
      end
      S_SQ_TEST: begin
        if (sts.t_one) begin
          set_res = 1'b1;
        end else begin
          cmd.op        = OP_T_DEC;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_RR;
        end
      end
      S_SQ_CHK: begin
        set_res = 1'b1;
        res_pp  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)               out_valid_r <= 1'b0;
    end
  end

  // result latched on the state's exit; the last one latched before DONE is taken
  always_ff @(posedge clk) begin
    if (set_res) begin
      res_pp_r  <= res_pp;
      res_inv_r <= res_inv;
    end
    if (state_r == S_DONE && out_free) begin
      out_word_r.probable_prime <= res_pp_r;
      out_word_r.invalid        <= res_inv_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `MRSB_ASSERT_NEXT(a_accept_to_check, in_acc, state_r == S_CHECK,
                    "accepted word did not start a check")
  `MRSB_ASSERT_NEXT(a_out_from_done, !out_valid_r, !out_valid_r || $past(state_r) == S_DONE,
                    "output word loaded outside DONE")
  `MRSB_ASSERT(a_result_exclusive, !(out_valid_r && out_word_r.probable_prime &&
                                     out_word_r.invalid), "prime and invalid both set")

endmodule

// ===== src/miller_rabin_single_base.sv =====
// One Miller-Rabin round on candidate n with base a.
// Channels: input word {candidate, witness_base} on in_valid/in_stall; result
//   word {probable_prime, invalid} on out_valid/out_stall. Low WIDTH bits used.
// One word is worked on at a time; in_stall is high from acceptance until the
//   result is moved into the output register. A new word may be taken while
//   a finished result still waits there.
// The steps are range checks, binary gcd, splitting n-1, and exponentiation
//   with up to 2*WIDTH modular products in the bit-serial multiplier; the
//   WIDTH-1 or fewer squarings that follow share the same budget of products,
//   since exponent bits and t sum to at most WIDTH.
// Out-of-range or even candidates finish straight after the range checks.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
// When the receiver stalls, the output word holds and the block finishes its
//   current word, then waits before taking the next result into the register.
// Depends on mrsb_pkg, mrsb_ctrl, mrsb_datapath, mrsb_mulmod.
module miller_rabin_single_base import mrsb_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mrsb_in_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output mrsb_out_t out_word
);

  mrsb_cmd_t cmd;
  mrsb_sts_t sts;

  mrsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

  mrsb_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule
